[src/ordered_list_store_core_assert.svh]
// Assertion macros for the ordered list store core.
`ifndef ORDERED_LIST_STORE_CORE_ASSERT_SVH
`define ORDERED_LIST_STORE_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, disabled during reset.
`define OLS_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ordered list store assertion failed");
// Next-cycle implication, disabled during reset.
`define OLS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ordered list store assertion failed");
`else
`define OLS_ASSERT_IMPL(label, clk, rst, ante, cons)
`define OLS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

[src/ols_pkg.sv]
// Shared constants, types and codes of the ordered list store.
package ols_pkg;

   // Storage geometry.
   localparam int CAPACITY   = 16;
   localparam int WORD_BITS  = 32;
   localparam int CNT_BITS   = $clog2(CAPACITY + 1);
   localparam int IDX_BITS   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int WHERE_BITS = 8;

   // Command codes.
   localparam logic [2:0] CMD_INSERT  = 3'd0;
   localparam logic [2:0] CMD_DEL_POS = 3'd1;
   localparam logic [2:0] CMD_DEL_VAL = 3'd2;
   localparam logic [2:0] CMD_GET     = 3'd3;
   localparam logic [2:0] CMD_FIND    = 3'd4;
   localparam logic [2:0] CMD_CLEAR   = 3'd5;

   // Status codes.
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;

   typedef logic [WORD_BITS-1:0] word_type;
   typedef logic [CNT_BITS-1:0]  cnt_type;
   typedef logic [IDX_BITS-1:0]  idx_type;

   typedef struct packed {
      logic [2:0]  command;
      logic [7:0]  position;
      logic [31:0] value;
   } req_type;

   typedef struct packed {
      logic [31:0] data;
      logic [7:0]  where;
      logic [1:0]  status;
      logic [7:0]  count;
   } rsp_type;

   // Broadcast control from the top level to every cell.
   typedef struct packed {
      logic                  insert;
      logic                  remove;
      logic                  by_value;
      logic [WHERE_BITS-1:0] target;
      word_type              value;
      cnt_type               count;
   } cell_ctrl_type;

   // Signals rippled from cell to cell, lowest position first.
   typedef struct packed {
      logic                  after;
      word_type              data;
      logic [WHERE_BITS-1:0] where;
   } chain_type;

endpackage

[src/ols_cell.sv]
// One list cell: holds a word, matches it and shifts with its neighbors.
module ols_cell import ols_pkg::*; (
   input  logic          clock,
   input  idx_type       index,
   input  cell_ctrl_type ctrl,
   input  word_type      left_word,
   input  word_type      right_word,
   input  chain_type     chain_in,
   output chain_type     chain_out,
   output word_type      word
);

   word_type word_ff;
   word_type word_in;
   logic     valid;
   logic     pos_hit;
   logic     val_hit;
   logic     at_target;

   // The cell is the target of the command, or the first matching word.
   always_comb begin
      valid     = CNT_BITS'(index) < ctrl.count;
      pos_hit   = (WHERE_BITS'(index) == ctrl.target) && (valid || ctrl.insert);
      val_hit   = valid && (word_ff == ctrl.value) && !chain_in.after;
      at_target = ctrl.by_value ? val_hit : pos_hit;
   end

   // Pass the hit flag, the hit word and the hit position down the row.
   always_comb begin
      chain_out.after = chain_in.after | at_target;
      chain_out.data  = chain_in.data | (at_target ? word_ff : '0);
      chain_out.where = chain_in.where | (at_target ? WHERE_BITS'(index) : '0);
   end

   // Insert opens a gap at the target; delete closes it from the right.
   always_comb begin
      word_in = word_ff;
      if (ctrl.insert) begin
         if (at_target) begin
            word_in = ctrl.value;
         end else if (chain_in.after) begin
            word_in = left_word;
         end
      end else if (ctrl.remove && (at_target || chain_in.after)) begin
         word_in = right_word;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word = word_ff;

endmodule

[src/ordered_list_store_core.sv]
// Top level of the ordered list store: request register, cell row, result register.
// Ordered list of up to CAPACITY words. A request is taken when start is high and busy
// is low; busy then stays high for one cycle while the request runs through the row of
// cells, and the result appears on rsp_data with rsp_valid high for exactly one cycle
// once the request has passed the request register and the result register. The
// receiver cannot stall, so every result must be captured in the cycle it is shown.
// No new request is accepted while one runs: in the execute cycle the match and position
// chain ripples through all cells and busy holds off the next request until the row and
// the count are updated. After reset the list is empty and no clearing pass is needed.
`include "ordered_list_store_core_assert.svh"
module ordered_list_store_core import ols_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   req_type       req_ff;
   logic          busy_ff;
   cnt_type       count_ff;
   cnt_type       count_in;
   logic          rsp_valid_ff;
   rsp_type       rsp_ff;
   rsp_type       rsp_in;
   cell_ctrl_type ctrl;
   chain_type     chain [CAPACITY+1];
   word_type      words [CAPACITY];
   logic          full;
   logic          found;
   logic          is_remove;
   logic          accept;

   assign accept = start && !busy_ff;
   assign busy   = busy_ff;

   // Request register and execute flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= accept;
      end
      if (accept) begin
         req_ff <= req_data;
      end
   end

   // Broadcast control for the cell row.
   always_comb begin
      full      = count_ff == cnt_type'(CAPACITY);
      is_remove = (req_ff.command == CMD_DEL_POS) || (req_ff.command == CMD_DEL_VAL);
      ctrl.insert   = busy_ff && (req_ff.command == CMD_INSERT) && !full;
      ctrl.remove   = busy_ff && is_remove;
      ctrl.by_value = (req_ff.command == CMD_DEL_VAL) || (req_ff.command == CMD_FIND);
      ctrl.value    = word_type'(req_ff.value);
      ctrl.count    = count_ff;
      if ((req_ff.command == CMD_INSERT) && (req_ff.position > WHERE_BITS'(count_ff))) begin
         ctrl.target = WHERE_BITS'(count_ff);
      end else begin
         ctrl.target = req_ff.position;
      end
   end

   // Row of cells; the chain starts empty at position zero.
   assign chain[0] = '0;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      word_type left_word;
      word_type right_word;
      if (i == 0) begin : g_first
         assign left_word = '0;
      end else begin : g_left
         assign left_word = words[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_word = '0;
      end else begin : g_right
         assign right_word = words[i+1];
      end
      ols_cell u_cell (
         .clock      (clock),
         .index      (idx_type'(i)),
         .ctrl       (ctrl),
         .left_word  (left_word),
         .right_word (right_word),
         .chain_in   (chain[i]),
         .chain_out  (chain[i+1]),
         .word       (words[i])
      );
   end

   assign found = chain[CAPACITY].after;

   // Result and new count for the running request.
   always_comb begin
      count_in      = count_ff;
      rsp_in.data   = '0;
      rsp_in.where  = '0;
      rsp_in.status = ST_NOT_FOUND;
      unique case (req_ff.command) inside
         CMD_INSERT: begin
            if (full) begin
               rsp_in.status = ST_FULL;
            end else begin
               rsp_in.status = ST_OK;
               rsp_in.where  = ctrl.target;
               count_in      = cnt_type'(count_ff + 1'b1);
            end
         end
         CMD_DEL_POS, CMD_DEL_VAL: begin
            if (found) begin
               rsp_in.status = ST_OK;
               rsp_in.data   = 32'(chain[CAPACITY].data);
               rsp_in.where  = chain[CAPACITY].where;
               count_in      = cnt_type'(count_ff - 1'b1);
            end
         end
         CMD_GET, CMD_FIND: begin
            if (found) begin
               rsp_in.status = ST_OK;
               rsp_in.data   = 32'(chain[CAPACITY].data);
               rsp_in.where  = chain[CAPACITY].where;
            end
         end
         CMD_CLEAR: begin
            rsp_in.status = ST_OK;
            count_in      = '0;
         end
         default: begin
            rsp_in.status = ST_NOT_FOUND;
         end
      endcase
      rsp_in.count = 8'(count_in);
   end

   // Count and result registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= busy_ff;
         if (busy_ff) begin
            count_ff <= count_in;
         end
      end
      if (busy_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // A taken request runs in the next cycle and answers in the one after.
   `OLS_ASSERT_NEXT(a_accept_runs, clock, reset, accept, busy_ff)
   `OLS_ASSERT_NEXT(a_run_answers, clock, reset, busy_ff, rsp_valid_ff)
   // The list never holds more than its capacity.
   `OLS_ASSERT_IMPL(a_count_bound, clock, reset, 1'b1, count_ff <= cnt_type'(CAPACITY))
   // A full report only comes from a full list.
   `OLS_ASSERT_IMPL(a_full_report, clock, reset, rsp_valid_ff && (rsp_ff.status == ST_FULL), rsp_ff.count == 8'(CAPACITY))

endmodule

[tb/tb_ordered_list_store_core.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the ordered list store core.
module tb_ordered_list_store_core;
   import ols_pkg::*;

   // Command codes that the block has no operation for.
   localparam logic [2:0] CMD_SPARE_LOW  = 3'd6;
   localparam logic [2:0] CMD_SPARE_HIGH = 3'd7;
   localparam int RANDOM_REQUESTS = 1750;
   localparam int PRINT_LIMIT     = 30;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;

   // Shadow copy of the list, updated when each request is accepted.
   word_type list_words [CAPACITY];
   int       list_len;
   rsp_type  expected_results [$];
   int       mismatch_count;
   word_type value_pool [8];

   ordered_list_store_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   task automatic report_mismatch(input string msg);
      if (mismatch_count < PRINT_LIMIT) begin
         $display("%0t: %s", $time, msg);
      end
      mismatch_count++;
   endtask

   function automatic req_type make_request(logic [2:0] cmd, logic [7:0] pos, word_type val);
      req_type r;
      r.command  = cmd;
      r.position = pos;
      r.value    = val;
      return r;
   endfunction

   // First position that holds the word, or -1 when it is absent.
   function automatic int find_first_word(word_type val);
      for (int i = 0; i < list_len; i++) begin
         if (list_words[i] == val) begin
            return i;
         end
      end
      return -1;
   endfunction

   // Takes one word out and closes the gap behind it.
   function automatic word_type remove_word(int pos);
      word_type w;
      w = list_words[pos];
      for (int i = pos; i + 1 < list_len; i++) begin
         list_words[i] = list_words[i + 1];
      end
      list_len--;
      return w;
   endfunction

   // Applies one request to the shadow list and returns the response it should give.
   function automatic rsp_type apply_list_command(req_type r);
      rsp_type  res;
      int       pos;
      int       hit;
      word_type val;
      res        = '0;
      res.status = ST_NOT_FOUND;
      pos        = r.position;
      val        = r.value[WORD_BITS-1:0];
      case (r.command)
         CMD_INSERT: begin
            if (list_len >= CAPACITY) begin
               res.status = ST_FULL;
            end else begin
               // A position past the end appends.
               if (pos > list_len) begin
                  pos = list_len;
               end
               for (int i = list_len; i > pos; i--) begin
                  list_words[i] = list_words[i - 1];
               end
               list_words[pos] = val;
               list_len++;
               res.where  = 8'(pos);
               res.status = ST_OK;
            end
         end
         CMD_DEL_POS: begin
            if (pos < list_len) begin
               res.data   = remove_word(pos);
               res.where  = 8'(pos);
               res.status = ST_OK;
            end
         end
         CMD_DEL_VAL: begin
            hit = find_first_word(val);
            if (hit >= 0) begin
               res.data   = remove_word(hit);
               res.where  = 8'(hit);
               res.status = ST_OK;
            end
         end
         CMD_GET: begin
            if (pos < list_len) begin
               res.data   = list_words[pos];
               res.where  = 8'(pos);
               res.status = ST_OK;
            end
         end
         CMD_FIND: begin
            hit = find_first_word(val);
            if (hit >= 0) begin
               res.data   = list_words[hit];
               res.where  = 8'(hit);
               res.status = ST_OK;
            end
         end
         CMD_CLEAR: begin
            list_len   = 0;
            res.status = ST_OK;
         end
         default: begin
         end
      endcase
      res.count = 8'(list_len);
      return res;
   endfunction

   // Presents one request and holds it until the block takes it.
   task automatic send_request(input req_type r);
      start    <= 1'b1;
      req_data <= r;
      forever begin
         @(posedge clock);
         if (!busy) begin
            break;
         end
      end
      expected_results.push_back(apply_list_command(r));
   endtask

   // Drops start for a while and puts junk on the request bus meanwhile.
   task automatic pause_sender(input int cycles);
      start    <= 1'b0;
      req_data <= make_request(3'($urandom), 8'($urandom), $urandom);
      repeat (cycles) @(posedge clock);
   endtask

   // Every response is compared with the oldest outstanding prediction.
   always @(posedge clock) begin
      rsp_type exp_rsp;
      if (!reset && rsp_valid) begin
         if (expected_results.size() == 0) begin
            report_mismatch("response with no request outstanding");
         end else begin
            exp_rsp = expected_results.pop_front();
            if (rsp_data.data !== exp_rsp.data) begin
               report_mismatch($sformatf("data %h, expected %h",
                                         rsp_data.data, exp_rsp.data));
            end
            if (rsp_data.where !== exp_rsp.where) begin
               report_mismatch($sformatf("where %0d, expected %0d",
                                         rsp_data.where, exp_rsp.where));
            end
            if (rsp_data.status !== exp_rsp.status) begin
               report_mismatch($sformatf("status %0d, expected %0d",
                                         rsp_data.status, exp_rsp.status));
            end
            if (rsp_data.count !== exp_rsp.count) begin
               report_mismatch($sformatf("count %0d, expected %0d",
                                         rsp_data.count, exp_rsp.count));
            end
         end
      end
   end

   // Get, find and delete by value on an empty list, plus a spare code.
   task automatic test_empty_list();
      send_request(make_request(CMD_GET, 8'd0, '0));
      send_request(make_request(CMD_FIND, 8'd0, 32'h0000_0000));
      send_request(make_request(CMD_DEL_VAL, 8'd255, 32'hFFFF_FFFF));
      send_request(make_request(CMD_SPARE_HIGH, 8'd255, 32'hFFFF_FFFF));
   endtask

   // Fills the list from the front, the back and the middle, then inserts once more.
   task automatic test_fill_to_capacity();
      logic [7:0] pos;
      word_type   val;
      for (int k = 0; k < CAPACITY; k++) begin
         case (k % 3)
            0:       pos = 8'd0;
            1:       pos = 8'd255;
            default: pos = 8'(list_len / 2);
         endcase
         if (k == 1) begin
            val = 32'h0000_0000;
         end else if (k == 2) begin
            val = 32'hFFFF_FFFF;
         end else if (k % 4 == 3) begin
            val = 32'h5A5A_0001;
         end else begin
            val = $urandom;
         end
         send_request(make_request(CMD_INSERT, pos, val));
      end
      send_request(make_request(CMD_INSERT, 8'd255, 32'h1234_5678));
   endtask

   // Last valid position, first invalid one, duplicates and clear.
   task automatic test_boundaries();
      send_request(make_request(CMD_GET, 8'(CAPACITY - 1), '0));
      send_request(make_request(CMD_GET, 8'(CAPACITY), '0));
      send_request(make_request(CMD_DEL_VAL, 8'd0, 32'h5A5A_0001));
      send_request(make_request(CMD_FIND, 8'd0, 32'h5A5A_0001));
      send_request(make_request(CMD_DEL_POS, 8'd0, '0));
      send_request(make_request(CMD_CLEAR, 8'd0, '0));
   endtask

   // Mixed traffic that drifts between filling and draining the list.
   task automatic test_random_traffic();
      req_type    r;
      logic [2:0] cmd;
      logic [7:0] pos;
      word_type   val;
      int         pick;
      int         ins_w;
      int         del_w;
      bit         growing;
      int         burst_left;
      growing    = 1'b1;
      burst_left = $urandom_range(1, 20);
      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         if ($urandom_range(0, 79) == 0) begin
            growing = !growing;
         end
         if ($urandom_range(0, 49) == 0) begin
            value_pool[$urandom_range(0, 7)] = $urandom;
         end
         ins_w = growing ? 50 : 14;
         del_w = growing ? 10 : 22;
         pick  = $urandom_range(0, 99);
         if (pick < ins_w) begin
            cmd = CMD_INSERT;
         end else if (pick < ins_w + del_w) begin
            cmd = CMD_DEL_POS;
         end else if (pick < ins_w + 2 * del_w) begin
            cmd = CMD_DEL_VAL;
         end else if (pick < 97) begin
            cmd = $urandom_range(0, 1) ? CMD_GET : CMD_FIND;
         end else if (pick < 98) begin
            cmd = CMD_CLEAR;
         end else begin
            cmd = $urandom_range(0, 1) ? CMD_SPARE_HIGH : CMD_SPARE_LOW;
         end
         // Positions mostly near the live range, sometimes anywhere.
         if ($urandom_range(0, 3) == 0) begin
            pos = 8'($urandom_range(0, 255));
         end else begin
            pos = 8'($urandom_range(0, list_len));
         end
         // Values mostly from a small pool so that lookups hit.
         if ($urandom_range(0, 9) < 7) begin
            val = value_pool[$urandom_range(0, 7)];
         end else begin
            val = $urandom;
         end
         r = make_request(cmd, pos, val);
         send_request(r);
         burst_left--;
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            if ($urandom_range(0, 9) < 7) begin
               pause_sender($urandom_range(1, 6));
            end
         end
      end
   endtask

   initial begin
      reset          = 1'b1;
      start          = 1'b0;
      req_data       = '0;
      list_len       = 0;
      mismatch_count = 0;
      for (int i = 0; i < CAPACITY; i++) begin
         list_words[i] = '0;
      end
      for (int i = 0; i < 8; i++) begin
         value_pool[i] = $urandom;
      end
      value_pool[0] = 32'h0000_0000;
      value_pool[1] = 32'hFFFF_FFFF;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_list();
      test_fill_to_capacity();
      test_boundaries();
      test_random_traffic();

      // Let the last responses drain before the verdict is printed.
      start <= 1'b0;
      while (expected_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("ordered_list_store_core: match");
      end else begin
         $display("ordered_list_store_core: mismatch");
      end
      $finish;
   end

   // Hard stop in case the block hangs.
   initial begin
      #2000000;
      $display("ordered_list_store_core: mismatch");
      $finish;
   end

endmodule

[files.f]
+incdir+src
src/ols_pkg.sv
src/ols_cell.sv
src/ordered_list_store_core.sv
tb/tb_ordered_list_store_core.sv
